### hdl/kci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_pkg: shared types and codes for the keyframe curve interpolator
// Holds the state encoding, command, status, mode and register index codes
// and the fixed datapath widths that follow from the 32-bit Q16.16 fields.
// ----------------------------------------------------------------------------
package kci_pkg;

  // lanes in the result word and width of one value
  localparam int LANES = 3;
  localparam int VW    = 32;

  // multiplier operand and product widths, accumulator width
  localparam int MW    = 34;
  localparam int PW    = 68;
  localparam int ACCW  = 70;

  // divider operand width (difference of two times)
  localparam int DW    = 34;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // status codes
  localparam logic [1:0] STAT_LOADED = 2'd0;
  localparam logic [1:0] STAT_EVAL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;

  // interpolation modes
  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_HERMITE = 2'd2;
  localparam logic [1:0] MODE_SPLINE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_COUNT   = 2'd0;
  localparam logic [1:0] CFG_INTERP_MODE = 2'd1;
  localparam logic [1:0] CFG_COMPONENTS  = 2'd2;

  // sequencer states
  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_RD0   = 14'b00000000000010,
    S_RDL   = 14'b00000000000100,
    S_C0    = 14'b00000000001000,
    S_C1    = 14'b00000000010000,
    S_C2    = 14'b00000000100000,
    S_SRCH  = 14'b00000001000000,
    S_SRCHW = 14'b00000010000000,
    S_FETCH = 14'b00000100000000,
    S_DIVS  = 14'b00001000000000,
    S_DIVI  = 14'b00010000000000,
    S_MUL   = 14'b00100000000000,
    S_CLAMP = 14'b01000000000000,
    S_PUSH  = 14'b10000000000000
  } state_t;

endpackage

### hdl/kci_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kci_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module kci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/keyframe_curve_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator: keyframe table with curve evaluation
// Holds keyframes in four RAMs and evaluates step, linear, hermite or
// spline curves at a query time, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Usage: every input word is either a keyframe load (cmd 0) or an evaluate
// (cmd 1); each gives exactly one result word on the out_ channel. The cfg_
// channel writes key_count, interp_mode and components; it is always ready.
// The user must write it only while the block is idle; nothing enforces it.
// Sequence: a load or an empty-table evaluate goes straight to the output
// register. A clamped evaluate reads the first and maybe the last key. An
// interior evaluate probes the cached segment and the next one, or else
// takes up to log2(MAX_KEYS)+1 search steps, then fetches four keys, runs
// up to 3 bit-serial divisions and then 8 products per lane on the shared
// multiplier.
// Throughput: one word at a time; the time RAM read port sets the search
// pace and the single multiplier and bit-serial divider set the rest.
// Reset clears the state, cached segment, output valid and config registers;
// table RAMs are not cleared. When the receiver stalls, the result waits in
// the output register while the next word is already accepted; a finished
// second result waits in its staging registers until the output frees.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator #(
  parameter int MAX_KEYS       = 64,
  parameter int MAX_COMPONENTS = 3,
  parameter int FRAC_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [5:0]         in_key_slot,
  input  logic signed [31:0] in_time_q16,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic signed [31:0] in_tan_in_x,
  input  logic signed [31:0] in_tan_in_y,
  input  logic signed [31:0] in_tan_in_z,
  input  logic signed [31:0] in_tan_out_x,
  input  logic signed [31:0] in_tan_out_y,
  input  logic signed [31:0] in_tan_out_z,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [5:0]         out_segment,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int RW  = MAX_COMPONENTS * kci_pkg::VW;
  localparam int AFW = FRAC_BITS + 1;
  localparam int HW  = FRAC_BITS + 4;
  localparam int DCW = $clog2(FRAC_BITS + 1);
  localparam logic [AFW-1:0] ONE_A = {1'b1, {FRAC_BITS{1'b0}}};

  // truncating rescale by 2^FRAC_BITS
  function automatic logic signed [kci_pkg::ACCW-1:0] tdiv(
    input logic signed [kci_pkg::ACCW-1:0] x);
    logic signed [kci_pkg::ACCW-1:0] bias;
    logic signed [kci_pkg::ACCW-1:0] b;
    bias = (70'sd1 <<< FRAC_BITS) - 70'sd1;
    b = x[kci_pkg::ACCW-1] ? x + bias : x;
    return b >>> FRAC_BITS;
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [kci_pkg::ACCW-1:0] x);
    if (x > 70'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -70'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  // configuration registers
  logic [6:0] kc_r;
  logic [1:0] mode_r;
  logic [1:0] comps_r;

  // sequencer and datapath registers
  kci_pkg::state_t        state_r;
  logic signed [31:0]     q_r;
  logic [CW-1:0]          cnt_r;
  logic [AW-1:0]          cache_r;
  logic [AW-1:0]          idx_r;
  logic [CW-1:0]          first_r;
  logic [CW-1:0]          len_r;
  logic [2:0]             fk_r;
  logic signed [31:0]     tm_r, t0_r, t1_r, tp_r;
  logic signed [31:0]     vm_r [kci_pkg::LANES];
  logic signed [31:0]     v0_r [kci_pkg::LANES];
  logic signed [31:0]     v1_r [kci_pkg::LANES];
  logic signed [31:0]     vp_r [kci_pkg::LANES];
  logic signed [31:0]     tout_r [kci_pkg::LANES];
  logic signed [31:0]     tin_r [kci_pkg::LANES];
  logic [AFW-1:0]         a_r, r0_r, r1_r, a2_r, a3_r;
  logic [1:0]             dsel_r;
  logic [DCW-1:0]         dcnt_r;
  logic [34:0]            rem_r;
  logic [33:0]            den_r;
  logic [FRAC_BITS-1:0]   quo_r;
  logic [1:0]             lane_r;
  logic [2:0]             j_r;
  logic                   ph_r;
  logic signed [kci_pkg::PW-1:0]   prod_r;
  logic signed [kci_pkg::ACCW-1:0] acc_r;
  logic signed [31:0]     m0_r, m1_r, lin_r;
  logic [1:0]             stat_r;
  logic [AW-1:0]          seg_r;
  logic signed [31:0]     res_r [kci_pkg::LANES];
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic signed [31:0]     out_x_r, out_y_r, out_z_r;
  logic [5:0]             out_segment_r;

  // ram ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  logic [31:0]            t_rdata;
  logic [RW-1:0]          v_wdata, ti_wdata, to_wdata;
  logic [RW-1:0]          v_rdata, ti_rdata, to_rdata;
  logic signed [31:0]     in_v [kci_pkg::LANES];
  logic signed [31:0]     in_ti [kci_pkg::LANES];
  logic signed [31:0]     in_to [kci_pkg::LANES];
  logic signed [31:0]     v_lane [kci_pkg::LANES];
  logic signed [31:0]     ti_lane [kci_pkg::LANES];
  logic signed [31:0]     to_lane [kci_pkg::LANES];
  logic [31:0]            slot_ext;

  assign in_ready  = (state_r == kci_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_z       = out_z_r;
  assign out_segment = out_segment_r;

  // load write port
  assign slot_ext  = 32'(in_key_slot);
  assign ram_we    = in_valid && in_ready && (in_cmd == kci_pkg::CMD_LOAD) &&
                     (slot_ext < 32'(MAX_KEYS));
  assign ram_waddr = slot_ext[AW-1:0];

  assign in_v[0]  = in_value_x;
  assign in_v[1]  = in_value_y;
  assign in_v[2]  = in_value_z;
  assign in_ti[0] = in_tan_in_x;
  assign in_ti[1] = in_tan_in_y;
  assign in_ti[2] = in_tan_in_z;
  assign in_to[0] = in_tan_out_x;
  assign in_to[1] = in_tan_out_y;
  assign in_to[2] = in_tan_out_z;

  // pack lanes into ram words and unpack read data
  always_comb begin
    for (int l = 0; l < MAX_COMPONENTS; l++) begin
      v_wdata[l*32 +: 32]  = in_v[l];
      ti_wdata[l*32 +: 32] = in_ti[l];
      to_wdata[l*32 +: 32] = in_to[l];
    end
    for (int l = 0; l < kci_pkg::LANES; l++) begin
      if (l < MAX_COMPONENTS) begin
        v_lane[l]  = v_rdata[(l % MAX_COMPONENTS)*32 +: 32];
        ti_lane[l] = ti_rdata[(l % MAX_COMPONENTS)*32 +: 32];
        to_lane[l] = to_rdata[(l % MAX_COMPONENTS)*32 +: 32];
      end else begin
        v_lane[l]  = '0;
        ti_lane[l] = '0;
        to_lane[l] = '0;
      end
    end
  end

  kci_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_time_q16),
    .raddr(ram_raddr), .rdata(t_rdata)
  );
  kci_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(v_wdata),
    .raddr(ram_raddr), .rdata(v_rdata)
  );
  kci_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_tan_in_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ti_wdata),
    .raddr(ram_raddr), .rdata(ti_rdata)
  );
  kci_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_tan_out_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(to_wdata),
    .raddr(ram_raddr), .rdata(to_rdata)
  );

  // table size and search helpers
  logic [CW-1:0]      live_cnt;
  logic signed [31:0] t_rd;
  logic [CW-1:0]      cm1, max_idx, c_ext, half, mid;
  logic               last_seg;
  logic [CW:0]        fa;
  logic [CW-1:0]      raddr_w;

  assign live_cnt = (32'(kc_r) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(kc_r);
  assign t_rd     = $signed(t_rdata);
  assign cm1      = cnt_r - CW'(1);
  assign max_idx  = cnt_r - CW'(2);
  assign c_ext    = CW'(cache_r);
  assign half     = len_r >> 1;
  assign mid      = first_r + half;
  assign last_seg = !((CW'(idx_r) + CW'(2)) < cnt_r);
  assign fa       = (CW+1)'(idx_r) + (CW+1)'(fk_r) - (CW+1)'(1);

  // shared read address of all four rams
  always_comb begin
    raddr_w = '0;
    unique case (state_r)
      kci_pkg::S_RD0: begin
        raddr_w = (cnt_r == CW'(1) || q_r <= t_rd) ? '0 : cm1;
      end
      kci_pkg::S_RDL: begin
        raddr_w = (q_r >= t_rd) ? cm1 : c_ext;
      end
      kci_pkg::S_C0:   raddr_w = c_ext + CW'(1);
      kci_pkg::S_C1:   raddr_w = c_ext + CW'(2);
      kci_pkg::S_SRCH: raddr_w = mid;
      kci_pkg::S_FETCH: begin
        raddr_w = (fa >= (CW+1)'(MAX_KEYS)) ? '0 : fa[CW-1:0];
      end
      default: raddr_w = '0;
    endcase
  end
  assign ram_raddr = raddr_w[AW-1:0];

  // divider operand selection
  logic signed [33:0] dt_w, dpos_w, dx, dd;
  logic               den_ok;
  logic [34:0]        rem2;
  logic               ge;
  logic [FRAC_BITS-1:0] quo_new;

  assign dt_w   = 34'(t1_r) - 34'(t0_r);
  assign dpos_w = (dt_w > 34'sd0) ? dt_w : 34'sd0;

  always_comb begin
    dx = dt_w;
    dd = dt_w;
    den_ok = 1'b0;
    unique case (dsel_r)
      2'd0: begin
        dx = 34'(q_r) - 34'(t0_r);
        dd = dt_w;
        den_ok = 1'b1;
      end
      2'd1: begin
        dd = 34'(t1_r) - 34'(tm_r);
        den_ok = (idx_r != '0);
      end
      2'd2: begin
        dd = 34'(tp_r) - 34'(t0_r);
        den_ok = !last_seg;
      end
      default: den_ok = 1'b0;
    endcase
    den_ok = den_ok && (dd > 34'sd0);
  end

  assign rem2    = {rem_r[33:0], 1'b0};
  assign ge      = rem2 >= {1'b0, den_r};
  assign quo_new = {quo_r[FRAC_BITS-2:0], ge};

  // blend basis from alpha powers
  logic signed [HW-1:0] a_s, a2_s, a3_s, one_s, h00, h10, h01, h11;
  assign a_s   = $signed(HW'(a_r));
  assign a2_s  = $signed(HW'(a2_r));
  assign a3_s  = $signed(HW'(a3_r));
  assign one_s = $signed(HW'(ONE_A));
  assign h00   = (a3_s <<< 1) - (a2_s <<< 1) - a2_s + one_s;
  assign h10   = a3_s - (a2_s <<< 1) + a_s;
  assign h01   = (a2_s <<< 1) + a2_s - (a3_s <<< 1);
  assign h11   = a3_s - a2_s;

  // multiplier operand selection
  logic signed [31:0] v0l, v1l, vml, vpl;
  logic signed [33:0] mA, mB, dv10;
  logic signed [33:0] a_m, r0_m, r1_m;
  logic               lane_live;
  logic signed [kci_pkg::ACCW-1:0] tp70, herm;

  assign v0l  = v0_r[lane_r];
  assign v1l  = v1_r[lane_r];
  assign vml  = vm_r[lane_r];
  assign vpl  = vp_r[lane_r];
  assign dv10 = 34'(v1l) - 34'(v0l);
  assign a_m  = $signed(34'(a_r));
  assign r0_m = $signed(34'(r0_r));
  assign r1_m = $signed(34'(r1_r));
  assign lane_live = (lane_r < comps_r) && (32'(lane_r) < 32'(MAX_COMPONENTS));
  assign tp70 = tdiv(kci_pkg::ACCW'(prod_r));
  assign herm = tdiv(acc_r + kci_pkg::ACCW'(prod_r));

  always_comb begin
    mA = '0;
    mB = '0;
    case (j_r)
      3'd0: begin
        mA = a_m;
        mB = a_m;
      end
      3'd1: begin
        mA = $signed(34'(a2_r));
        mB = a_m;
      end
      3'd2: begin
        unique case (mode_r)
          kci_pkg::MODE_LINEAR: begin
            mA = dv10;
            mB = a_m;
          end
          kci_pkg::MODE_HERMITE: begin
            mA = 34'(v1l) - 34'(vml);
            mB = r0_m;
          end
          kci_pkg::MODE_SPLINE: begin
            mA = 34'(tout_r[lane_r]);
            mB = dpos_w;
          end
          default: begin
            mA = '0;
            mB = '0;
          end
        endcase
      end
      3'd3: begin
        unique case (mode_r)
          kci_pkg::MODE_HERMITE: begin
            mA = 34'(vpl) - 34'(v0l);
            mB = r1_m;
          end
          kci_pkg::MODE_SPLINE: begin
            mA = 34'(tin_r[lane_r]);
            mB = dpos_w;
          end
          default: begin
            mA = '0;
            mB = '0;
          end
        endcase
      end
      3'd4: begin
        mA = 34'(h00);
        mB = 34'(v0l);
      end
      3'd5: begin
        mA = 34'(h10);
        mB = 34'(m0_r);
      end
      3'd6: begin
        mA = 34'(h01);
        mB = 34'(v1l);
      end
      default: begin
        mA = 34'(h11);
        mB = 34'(m1_r);
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r    <= 7'd0;
      mode_r  <= kci_pkg::MODE_LINEAR;
      comps_r <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kci_pkg::CFG_KEY_COUNT:   kc_r    <= cfg_data[6:0];
        kci_pkg::CFG_INTERP_MODE: mode_r  <= cfg_data[1:0];
        kci_pkg::CFG_COMPONENTS:  comps_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kci_pkg::S_IDLE;
      cache_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output drains; a push in the same cycle refills it below
      if (out_valid_r && out_ready && state_r != kci_pkg::S_PUSH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        kci_pkg::S_IDLE: begin
          if (in_valid) begin
            seg_r  <= '0;
            for (int l = 0; l < kci_pkg::LANES; l++) begin
              res_r[l] <= '0;
            end
            if (in_cmd == kci_pkg::CMD_LOAD) begin
              stat_r  <= kci_pkg::STAT_LOADED;
              state_r <= kci_pkg::S_PUSH;
            end else if (live_cnt == '0) begin
              stat_r  <= kci_pkg::STAT_EMPTY;
              state_r <= kci_pkg::S_PUSH;
            end else begin
              q_r     <= in_time_q16;
              cnt_r   <= live_cnt;
              state_r <= kci_pkg::S_RD0;
            end
          end
        end
        // first key: clamp low or read last key
        kci_pkg::S_RD0: begin
          if (cnt_r == CW'(1) || q_r <= t_rd) begin
            seg_r   <= '0;
            state_r <= kci_pkg::S_CLAMP;
          end else begin
            state_r <= kci_pkg::S_RDL;
          end
        end
        // last key: clamp high or probe the cache
        kci_pkg::S_RDL: begin
          if (q_r >= t_rd) begin
            seg_r   <= cm1[AW-1:0];
            state_r <= kci_pkg::S_CLAMP;
          end else if (c_ext <= max_idx) begin
            state_r <= kci_pkg::S_C0;
          end else begin
            first_r <= '0;
            len_r   <= cnt_r;
            state_r <= kci_pkg::S_SRCH;
          end
        end
        kci_pkg::S_C0: begin
          if (q_r < t_rd) begin
            first_r <= '0;
            len_r   <= cnt_r;
            state_r <= kci_pkg::S_SRCH;
          end else if (c_ext == max_idx) begin
            idx_r   <= cache_r;
            fk_r    <= '0;
            state_r <= kci_pkg::S_FETCH;
          end else begin
            state_r <= kci_pkg::S_C1;
          end
        end
        kci_pkg::S_C1: begin
          if (q_r < t_rd) begin
            idx_r   <= cache_r;
            fk_r    <= '0;
            state_r <= kci_pkg::S_FETCH;
          end else if (c_ext + CW'(1) == max_idx) begin
            idx_r   <= cache_r + AW'(1);
            cache_r <= cache_r + AW'(1);
            fk_r    <= '0;
            state_r <= kci_pkg::S_FETCH;
          end else begin
            state_r <= kci_pkg::S_C2;
          end
        end
        kci_pkg::S_C2: begin
          if (q_r < t_rd) begin
            idx_r   <= cache_r + AW'(1);
            cache_r <= cache_r + AW'(1);
            fk_r    <= '0;
            state_r <= kci_pkg::S_FETCH;
          end else begin
            first_r <= '0;
            len_r   <= cnt_r;
            state_r <= kci_pkg::S_SRCH;
          end
        end
        // upper-bound search: each probe issues in S_SRCH and is compared in S_SRCHW
        kci_pkg::S_SRCH: begin
          if (len_r == '0) begin
            if (first_r == '0) begin
              idx_r   <= '0;
              cache_r <= '0;
            end else if (first_r == cnt_r) begin
              idx_r   <= max_idx[AW-1:0];
              cache_r <= max_idx[AW-1:0];
            end else begin
              idx_r   <= AW'(first_r - CW'(1));
              cache_r <= AW'(first_r - CW'(1));
            end
            fk_r    <= '0;
            state_r <= kci_pkg::S_FETCH;
          end else begin
            state_r <= kci_pkg::S_SRCHW;
          end
        end
        kci_pkg::S_SRCHW: begin
          if (!(q_r < t_rd)) begin
            first_r <= mid + CW'(1);
            len_r   <= len_r - half - CW'(1);
          end else begin
            len_r   <= half;
          end
          state_r <= kci_pkg::S_SRCH;
        end
        // fetch keys idx-1 .. idx+2
        kci_pkg::S_FETCH: begin
          case (fk_r)
            3'd1: begin
              tm_r <= t_rd;
              for (int l = 0; l < kci_pkg::LANES; l++) vm_r[l] <= v_lane[l];
            end
            3'd2: begin
              t0_r <= t_rd;
              for (int l = 0; l < kci_pkg::LANES; l++) begin
                v0_r[l]   <= v_lane[l];
                tout_r[l] <= to_lane[l];
              end
            end
            3'd3: begin
              t1_r <= t_rd;
              for (int l = 0; l < kci_pkg::LANES; l++) begin
                v1_r[l]  <= v_lane[l];
                tin_r[l] <= ti_lane[l];
              end
            end
            3'd4: begin
              tp_r <= t_rd;
              for (int l = 0; l < kci_pkg::LANES; l++) vp_r[l] <= v_lane[l];
            end
            default: ;
          endcase
          fk_r <= fk_r + 3'd1;
          if (fk_r == 3'd4) begin
            dsel_r  <= 2'd0;
            state_r <= kci_pkg::S_DIVS;
          end
        end
        // division setup: trivial cases finish here
        kci_pkg::S_DIVS: begin
          if (!den_ok || dx <= 34'sd0 || dx >= dd) begin
            unique case (dsel_r)
              2'd0:    a_r  <= (den_ok && dx > 34'sd0) ? ONE_A : '0;
              2'd1:    r0_r <= (den_ok && dx > 34'sd0) ? ONE_A : '0;
              default: r1_r <= (den_ok && dx > 34'sd0) ? ONE_A : '0;
            endcase
            if (dsel_r == 2'd2) begin
              lane_r  <= '0;
              j_r     <= '0;
              ph_r    <= 1'b0;
              state_r <= kci_pkg::S_MUL;
            end else begin
              dsel_r <= dsel_r + 2'd1;
            end
          end else begin
            rem_r   <= 35'($unsigned(dx));
            den_r   <= $unsigned(dd);
            quo_r   <= '0;
            dcnt_r  <= '0;
            state_r <= kci_pkg::S_DIVI;
          end
        end
        // restoring division, one quotient bit per cycle
        kci_pkg::S_DIVI: begin
          rem_r  <= ge ? rem2 - {1'b0, den_r} : rem2;
          quo_r  <= quo_new;
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(FRAC_BITS - 1)) begin
            unique case (dsel_r)
              2'd0:    a_r  <= {1'b0, quo_new};
              2'd1:    r0_r <= {1'b0, quo_new};
              default: r1_r <= {1'b0, quo_new};
            endcase
            if (dsel_r == 2'd2) begin
              lane_r  <= '0;
              j_r     <= '0;
              ph_r    <= 1'b0;
              state_r <= kci_pkg::S_MUL;
            end else begin
              dsel_r  <= dsel_r + 2'd1;
              state_r <= kci_pkg::S_DIVS;
            end
          end
        end
        // shared multiplier: issue, then write back
        kci_pkg::S_MUL: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= kci_pkg::PW'(mA) * kci_pkg::PW'(mB);
          end else begin
            j_r <= j_r + 3'd1;
            case (j_r)
              3'd0: a2_r <= prod_r[FRAC_BITS +: AFW];
              3'd1: a3_r <= prod_r[FRAC_BITS +: AFW];
              3'd2: begin
                lin_r <= sat32(kci_pkg::ACCW'(v0l) + tp70);
                m0_r  <= (mode_r == kci_pkg::MODE_HERMITE && idx_r == '0) ?
                         sat32(kci_pkg::ACCW'(dv10)) : sat32(tp70);
              end
              3'd3: begin
                m1_r <= (mode_r == kci_pkg::MODE_HERMITE && last_seg) ?
                        sat32(kci_pkg::ACCW'(dv10)) : sat32(tp70);
              end
              3'd4: acc_r <= kci_pkg::ACCW'(prod_r);
              3'd5, 3'd6: acc_r <= acc_r + kci_pkg::ACCW'(prod_r);
              default: begin
                if (!lane_live) begin
                  res_r[lane_r] <= '0;
                end else if (mode_r == kci_pkg::MODE_STEP) begin
                  res_r[lane_r] <= v0l;
                end else if (mode_r == kci_pkg::MODE_LINEAR) begin
                  res_r[lane_r] <= lin_r;
                end else begin
                  res_r[lane_r] <= sat32(herm);
                end
                if (lane_r == 2'd2) begin
                  stat_r  <= kci_pkg::STAT_EVAL;
                  seg_r   <= idx_r;
                  state_r <= kci_pkg::S_PUSH;
                end else begin
                  lane_r <= lane_r + 2'd1;
                end
              end
            endcase
          end
        end
        // end key value
        kci_pkg::S_CLAMP: begin
          for (int l = 0; l < kci_pkg::LANES; l++) begin
            res_r[l] <= ((2'(l) < comps_r) && (l < MAX_COMPONENTS)) ? v_lane[l] : '0;
          end
          stat_r  <= kci_pkg::STAT_EVAL;
          state_r <= kci_pkg::S_PUSH;
        end
        // hand the word to the output register
        kci_pkg::S_PUSH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= stat_r;
            out_x_r       <= res_r[0];
            out_y_r       <= res_r[1];
            out_z_r       <= res_r[2];
            out_segment_r <= 6'(seg_r);
            state_r       <= kci_pkg::S_IDLE;
          end
        end
        default: state_r <= kci_pkg::S_IDLE;
      endcase
    end
  end

  // cached segment always names a segment with a right key
  a_cache_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cache_r) <= 32'(MAX_KEYS - 2))
    else $error("cached segment out of range");

  // a fetched segment lies inside the live table
  a_fetch_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kci_pkg::S_FETCH) |-> ((CW'(idx_r) + CW'(1)) < cnt_r))
    else $error("segment beyond live keys");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kci_pkg::S_DIVI) |-> (rem_r < {1'b0, den_r}))
    else $error("divider remainder overflow");

  // ratios are clamped before blending
  a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kci_pkg::S_MUL) |-> (a_r <= ONE_A && r0_r <= ONE_A && r1_r <= ONE_A))
    else $error("ratio above one");

  // a staged word reaches a free output register next cycle
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kci_pkg::S_PUSH && !out_valid_r) |=> out_valid_r)
    else $error("result word lost");

endmodule

### sim/keyframe_curve_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator_tb: self-checking bench for the curve block
// Loads keyframe tables, evaluates curves in all four modes over several
// register settings, and compares every result word against an in-bench
// fixed-point predictor, with random idling and a long receiver stall.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator_tb;

  typedef struct {
    logic               cmd;
    logic [5:0]         slot;
    logic signed [31:0] tq;
    logic signed [31:0] val [3];
    logic signed [31:0] tin [3];
    logic signed [31:0] tout [3];
  } key_word_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] lane [3];
    logic [5:0]         seg;
  } curve_word_t;

  localparam longint ONE_Q   = 64'sd65536;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // curve predictor and store of expected result words
  class curve_scoreboard;
    longint      key_time [64];
    longint      key_val [192];
    longint      tan_in [192];
    longint      tan_out [192];
    int unsigned seg_cache;
    int unsigned key_count;
    logic [1:0]  mode;
    int unsigned comps;
    curve_word_t pending_words [$];
    int          errors;

    function new();
      seg_cache = 0;
      key_count = 0;
      mode      = kci_pkg::MODE_LINEAR;
      comps     = 3;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        kci_pkg::CFG_KEY_COUNT:   key_count = data[6:0];
        kci_pkg::CFG_INTERP_MODE: mode = data[1:0];
        kci_pkg::CFG_COMPONENTS:  comps = data[1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat(longint v);
      return clip(v, S32_MIN, S32_MAX);
    endfunction

    function bit seg_ok(int unsigned s, int unsigned max_idx, longint t);
      if (s > max_idx || t < key_time[s]) return 0;
      return s == max_idx || t < key_time[s+1];
    endfunction

    // cached probe, then next segment, then upper-bound search
    function int unsigned locate(longint t, int unsigned n);
      int unsigned max_idx, first, len, half, mid, c;
      max_idx = n - 2;
      first = 0;
      len = n;
      c = seg_cache;
      if (c <= max_idx && t >= key_time[c]) begin
        if (seg_ok(c, max_idx, t)) return c;
        if (c + 1 <= max_idx && seg_ok(c + 1, max_idx, t)) begin
          seg_cache = c + 1;
          return seg_cache;
        end
      end
      while (len > 0) begin
        half = len / 2;
        mid = first + half;
        if (!(t < key_time[mid])) begin
          first = mid + 1;
          len = len - half - 1;
        end else begin
          len = half;
        end
      end
      if (first == 0) seg_cache = 0;
      else if (first == n) seg_cache = max_idx;
      else seg_cache = first - 1;
      return seg_cache;
    endfunction

    function longint blend(longint a, longint p0, longint m0, longint p1, longint m1);
      longint a2, a3, h00, h10, h01, h11, acc;
      a2 = a * a / ONE_Q;
      a3 = a2 * a / ONE_Q;
      h00 = 2 * a3 - 3 * a2 + ONE_Q;
      h10 = a3 - 2 * a2 + a;
      h01 = -2 * a3 + 3 * a2;
      h11 = a3 - a2;
      acc = h00 * p0 + h10 * sat(m0) + h01 * p1 + h11 * sat(m1);
      return sat(acc / ONE_Q);
    endfunction

    function longint ratio(longint dt, longint span);
      if (span <= 0) return 0;
      return clip(dt * ONE_Q / span, 0, ONE_Q);
    endfunction

    function void note_word(key_word_t w);
      curve_word_t r;
      longint res [3];
      longint t, dt, a, dpos, r0, r1, v0, v1, m0, m1;
      int unsigned n, lanes, idx, b0, b1;
      r.status = kci_pkg::STAT_EVAL;
      r.seg = 0;
      res = '{0, 0, 0};
      lanes = comps < 3 ? comps : 3;
      t = w.tq;
      n = key_count > 64 ? 64 : key_count;
      if (w.cmd == kci_pkg::CMD_LOAD) begin
        r.status = kci_pkg::STAT_LOADED;
        key_time[w.slot] = w.tq;
        for (int i = 0; i < 3; i++) begin
          key_val[w.slot*3+i] = w.val[i];
          tan_in[w.slot*3+i]  = w.tin[i];
          tan_out[w.slot*3+i] = w.tout[i];
        end
      end else if (n == 0) begin
        r.status = kci_pkg::STAT_EMPTY;
      end else if (n == 1 || t <= key_time[0]) begin
        for (int i = 0; i < lanes; i++) res[i] = key_val[i];
      end else if (t >= key_time[n-1]) begin
        r.seg = 6'(n - 1);
        for (int i = 0; i < lanes; i++) res[i] = key_val[(n-1)*3+i];
      end else begin
        idx = locate(t, n);
        b0 = idx * 3;
        b1 = (idx + 1) * 3;
        dt = key_time[idx+1] - key_time[idx];
        a = dt > 0 ? clip((t - key_time[idx]) * ONE_Q / dt, 0, ONE_Q) : 0;
        dpos = dt > 0 ? dt : 0;
        r0 = 0;
        r1 = 0;
        r.seg = 6'(idx);
        if (idx > 0) r0 = ratio(dt, key_time[idx+1] - key_time[idx-1]);
        if (idx + 2 < n) r1 = ratio(dt, key_time[idx+2] - key_time[idx]);
        for (int i = 0; i < lanes; i++) begin
          v0 = key_val[b0+i];
          v1 = key_val[b1+i];
          case (mode)
            kci_pkg::MODE_STEP:   res[i] = v0;
            kci_pkg::MODE_LINEAR: res[i] = sat(v0 + (v1 - v0) * a / ONE_Q);
            kci_pkg::MODE_HERMITE: begin
              m0 = idx == 0 ? v1 - v0 : (v1 - key_val[(idx-1)*3+i]) * r0 / ONE_Q;
              m1 = idx + 2 >= n ? v1 - v0 : (key_val[(idx+2)*3+i] - v0) * r1 / ONE_Q;
              res[i] = blend(a, v0, m0, v1, m1);
            end
            default: begin
              m0 = tan_out[b0+i] * dpos / ONE_Q;
              m1 = tan_in[b1+i] * dpos / ONE_Q;
              res[i] = blend(a, v0, m0, v1, m1);
            end
          endcase
        end
      end
      for (int i = 0; i < 3; i++) r.lane[i] = res[i][31:0];
      pending_words.push_back(r);
    endfunction

    function void check_word(curve_word_t got);
      curve_word_t exp_w;
      string       lane_names [3];
      lane_names = '{"out_x", "out_y", "out_z"};
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
      for (int i = 0; i < 3; i++)
        if (got.lane[i] !== exp_w.lane[i]) begin
          $error("%s: expected %0d, got %0d", lane_names[i], exp_w.lane[i], got.lane[i]);
          errors++;
        end
      if (got.seg !== exp_w.seg) begin
        $error("segment: expected %0d, got %0d", exp_w.seg, got.seg);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic               in_cmd = 0;
  logic [5:0]         in_key_slot = 0;
  logic signed [31:0] in_time_q16 = 0;
  logic signed [31:0] in_value_x = 0, in_value_y = 0, in_value_z = 0;
  logic signed [31:0] in_tan_in_x = 0, in_tan_in_y = 0, in_tan_in_z = 0;
  logic signed [31:0] in_tan_out_x = 0, in_tan_out_y = 0, in_tan_out_z = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [1:0]         out_status;
  logic signed [31:0] out_x, out_y, out_z;
  logic [5:0]         out_segment;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 0;
  logic [7:0]         cfg_data = 0;

  curve_scoreboard sb = new();
  int tx_idle_pct = 10;
  int rx_idle_pct = 69;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int words_sent = 0;

  keyframe_curve_interpolator uut (.*);

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result word check
  always @(posedge clk) begin
    curve_word_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.lane[0] = out_x;
      got.lane[1] = out_y;
      got.lane[2] = out_z;
      got.seg = out_segment;
      sb.check_word(got);
    end
  end

  // send one word, idling first at random
  task automatic send_word(key_word_t w);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= w.cmd;
    in_key_slot <= w.slot;
    in_time_q16 <= w.tq;
    in_value_x <= w.val[0];
    in_value_y <= w.val[1];
    in_value_z <= w.val[2];
    in_tan_in_x <= w.tin[0];
    in_tan_in_y <= w.tin[1];
    in_tan_in_z <= w.tin[2];
    in_tan_out_x <= w.tout[0];
    in_tan_out_y <= w.tout[1];
    in_tan_out_z <= w.tout[2];
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  // wait until every expected word has come back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cfg(int kc, logic [1:0] md, int cp);
    drain();
    write_cfg(kci_pkg::CFG_KEY_COUNT, kc[7:0]);
    write_cfg(kci_pkg::CFG_INTERP_MODE, {6'd0, md});
    write_cfg(kci_pkg::CFG_COMPONENTS, cp[7:0]);
  endtask

  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_load(int slot, logic signed [31:0] tq);
    key_word_t w;
    w.cmd = kci_pkg::CMD_LOAD;
    w.slot = slot[5:0];
    w.tq = tq;
    for (int i = 0; i < 3; i++) begin
      w.val[i] = rand_fixed();
      w.tin[i] = rand_fixed();
      w.tout[i] = rand_fixed();
    end
    send_word(w);
  endtask

  // slot and keyframe fields are random on evaluate since they are ignored there
  task automatic send_eval(logic signed [31:0] tq);
    key_word_t w;
    w.cmd = kci_pkg::CMD_EVAL;
    w.slot = 6'($urandom);
    w.tq = tq;
    for (int i = 0; i < 3; i++) begin
      w.val[i] = $urandom;
      w.tin[i] = $urandom;
      w.tout[i] = $urandom;
    end
    send_word(w);
  endtask

  // fill all 64 slots: non-decreasing times with varied gaps, or noise
  task automatic load_table(int kind);
    longint tk;
    tk = kind == 1 ? S32_MIN : -64'sd1000000 - $urandom_range(0, 1 << 20);
    for (int s = 0; s < 64; s++) begin
      if (kind == 3) begin
        send_load(s, $urandom);
      end else begin
        send_load(s, tk[31:0]);
        case ($urandom_range(kind == 1 ? 4 : 3))
          0: tk += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255);
          1, 2: tk += $urandom_range(1, 1 << 20);
          3: tk += $urandom_range(1 << 16, 1 << 22);
          default: tk += 64'sd1 << 26;
        endcase
        if (s == 62 && kind == 1) tk = S32_MAX;
        if (tk > S32_MAX) tk = S32_MAX;
      end
    end
  endtask

  function automatic logic signed [31:0] sat_q(longint t);
    return t > S32_MAX ? 32'sh7fffffff : (t < S32_MIN ? 32'sh80000000 : t[31:0]);
  endfunction

  // query time near a key of the live table, or anywhere
  function automatic logic signed [31:0] pick_query(int n);
    int k;
    longint t;
    k = $urandom_range(0, (n > 64 ? 64 : (n < 1 ? 1 : n)) - 1);
    t = sb.key_time[k];
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'sh80000000;
      2: return 32'sh7fffffff;
      3: t = t - 1;
      4: t = t + 1;
      5: ;
      default: t = t + $urandom_range(0, 1 << 20);
    endcase
    return sat_q(t);
  endfunction

  // stimulus
  initial begin
    int kc, phase;
    logic [1:0] md;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table answers zeros
    send_eval(0);
    load_table(0);
    send_eval(32'sh7fffffff);

    // every mode at the clamp ends, on a key, mid segment and walking forward
    for (int m = 0; m < 4; m++) begin
      md = 2'(m);
      set_cfg(64, md, 3);
      send_eval(32'sh80000000);
      send_eval(32'sh7fffffff);
      send_eval(sb.key_time[5][31:0]);
      send_eval(sat_q(sb.key_time[0] + 1));
      send_eval(sat_q(sb.key_time[62] + 1));
      send_eval(sat_q(sb.key_time[63] - 1));
    end
    set_cfg(1, kci_pkg::MODE_SPLINE, 1);
    send_eval(0);
    set_cfg(127, kci_pkg::MODE_HERMITE, 2);
    send_eval(sat_q(sb.key_time[30] + 7));

    // random phases over settings and tables
    phase = 0;
    while (words_sent < 500) begin
      if (words_sent < 200) begin
        tx_idle_pct = 10;
        rx_idle_pct = 69;
      end else if (words_sent < 380) begin
        tx_idle_pct = 69;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(5))
        0: kc = $urandom_range(0, 3);
        1: kc = 64;
        2: kc = 127;
        default: kc = $urandom_range(2, 64);
      endcase
      md = 2'(phase % 4);
      set_cfg(kc, md, 1 + (phase / 4) % 3);
      if (phase % 5 == 4) load_table($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
      if (phase == 6) hold_req++;
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(99) < 8)
          send_load($urandom_range(0, 63), pick_query(64));
        else
          send_eval(pick_query(kc));
      end
      phase++;
    end

    drain();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // overall limit
  initial begin
    #(30_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
